// ===== rtl/ccds_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Clock calendar package
// Shared types, codes, constants and small arithmetic helpers.
// ---------------------------------------------------------------------------
package ccds_pkg;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_TIME_SET = 2'd1,
		OP_DATE_SET = 2'd2,
		OP_KEY      = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		RUNNING   = 2'd0,
		TIME_EDIT = 2'd1,
		DATE_EDIT = 2'd2
	} mode_t;

	localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [3:0] KEY_LEFT      = 4'd10;
	localparam logic [3:0] KEY_RIGHT     = 4'd11;

	localparam logic [2:0] CUR_HI_TENS  = 3'd0;
	localparam logic [2:0] CUR_HI_UNITS = 3'd1;
	localparam logic [2:0] CUR_MD_TENS  = 3'd2;
	localparam logic [2:0] CUR_MD_UNITS = 3'd3;
	localparam logic [2:0] CUR_LO_TENS  = 3'd4;
	localparam logic [2:0] CUR_LAST     = 3'd5;

	localparam logic [5:0] SEC_PER_MIN   = 6'd60;
	localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
	localparam logic [4:0] HOUR_PER_DAY  = 5'd24;
	localparam logic [3:0] MONTH_LAST    = 4'd12;
	localparam logic [6:0] YEAR_LAST     = 7'd99;
	localparam logic [6:0] HOUR_LAST     = 7'd23;
	localparam logic [4:0] HOUR_CLAMP    = 5'd20;

	localparam logic [7:0] TPS_RESET     = 8'd100;
	localparam int         APB_ADDR_W    = 3;
	localparam logic       REG_IDX_TPS   = 1'b0;

	typedef struct packed {
		logic [4:0] out_hours;
		logic [5:0] out_minutes;
		logic [5:0] out_seconds;
		logic [4:0] out_day;
		logic [3:0] out_month;
		logic [6:0] out_year;
		logic [1:0] mode_now;
		logic [2:0] cursor_now;
		logic       second_advanced;
		logic       day_advanced;
	} res_t;

	// Tens digit of a value below 100, by reciprocal multiplication.
	function automatic logic [3:0] div10(input logic [6:0] v);
		logic [14:0] prod;
		prod = 15'(v) * 15'd205;
		return prod[14:11];
	endfunction

	function automatic logic [6:0] mul10(input logic [3:0] t);
		return 7'({t, 3'b000}) + 7'({t, 1'b0});
	endfunction

	function automatic logic [3:0] units10(input logic [6:0] v, input logic [3:0] t);
		logic [6:0] r;
		r = v - mul10(t);
		return r[3:0];
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic [6:0] y);
		logic [4:0] len;
		if (m == 4'd2) begin
			len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
		end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ccds_evt_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Event channel
// Carries one clock event item with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface ccds_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [3:0] key_code;

	modport source (output valid, opcode, key_code, input ready);
	modport sink (input valid, opcode, key_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/ccds_res_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Result channel
// Carries one clock and calendar result item with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface ccds_res_if;
	logic       valid;
	logic       ready;
	logic [4:0] out_hours;
	logic [5:0] out_minutes;
	logic [5:0] out_seconds;
	logic [4:0] out_day;
	logic [3:0] out_month;
	logic [6:0] out_year;
	logic [1:0] mode_now;
	logic [2:0] cursor_now;
	logic       second_advanced;
	logic       day_advanced;

	modport source (
		output valid, out_hours, out_minutes, out_seconds, out_day, out_month, out_year,
		       mode_now, cursor_now, second_advanced, day_advanced,
		input  ready
	);
	modport sink (
		input  valid, out_hours, out_minutes, out_seconds, out_day, out_month, out_year,
		       mode_now, cursor_now, second_advanced, day_advanced,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/ccds_apb_regs.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style port holding the ticks-per-second prescaler limit.
// ---------------------------------------------------------------------------
module ccds_apb_regs
	import ccds_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output logic      [7:0]            tps
);
	logic [7:0] tps_q;
	logic       hit;

	assign hit    = (paddr[2] == REG_IDX_TPS);
	assign pready = 1'b1;
	assign tps    = tps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			tps_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {24'd0, tps_q};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ccds_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Clock and calendar core
// Holds the time, date, prescaler, mode and cursor and computes their next
// values for one event item.
// ---------------------------------------------------------------------------
module ccds_core
	import ccds_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [1:0] opcode,
	input  wire logic [3:0] key_code,
	input  wire logic [7:0] tps,
	output res_t            res_d
);
	opcode_t    op;
	logic [4:0] hour_q, hour_d, day_q, day_d;
	logic [5:0] minute_q, minute_d, second_q, second_d;
	logic [3:0] month_q, month_d;
	logic [6:0] year_q, year_d;
	logic [7:0] prescale_q, prescale_d, prescale_inc;
	mode_t      mode_q, mode_d, target;
	logic [2:0] cursor_q, cursor_d, cursor_inc, cursor_dec;
	logic       sec_flag, day_flag;

	logic [5:0] second_inc, minute_inc;
	logic [4:0] hour_inc;
	logic [5:0] day_inc;
	logic [3:0] month_inc;
	logic [6:0] year_inc;
	logic [4:0] lim_cur, lim_new;

	logic [3:0] hr_t, hr_u, mi_t, mi_u, se_t, se_u;
	logic [3:0] dy_t, dy_u, mo_t, mo_u, yr_t, yr_u;

	logic [4:0] ed_hour, ed_day;
	logic [5:0] ed_minute, ed_second;
	logic [3:0] ed_month;
	logic [6:0] ed_year;
	logic       ed_ok;
	logic [6:0] cand;

	assign op = opcode_t'(opcode);

	assign hr_t = div10(7'(hour_q));
	assign hr_u = units10(7'(hour_q), hr_t);
	assign mi_t = div10(7'(minute_q));
	assign mi_u = units10(7'(minute_q), mi_t);
	assign se_t = div10(7'(second_q));
	assign se_u = units10(7'(second_q), se_t);
	assign dy_t = div10(7'(day_q));
	assign dy_u = units10(7'(day_q), dy_t);
	assign mo_t = div10(7'(month_q));
	assign mo_u = units10(7'(month_q), mo_t);
	assign yr_t = div10(year_q);
	assign yr_u = units10(year_q, yr_t);

	assign prescale_inc = prescale_q + 8'd1;
	assign second_inc   = second_q + 6'd1;
	assign minute_inc   = minute_q + 6'd1;
	assign hour_inc     = hour_q + 5'd1;
	assign day_inc      = {1'b0, day_q} + 6'd1;
	assign month_inc    = month_q + 4'd1;
	assign year_inc     = year_q + 7'd1;
	assign lim_cur      = month_length(month_q, year_q);
	assign lim_new      = month_length(ed_month, ed_year);

	assign cursor_inc = (cursor_q >= CUR_LAST) ? 3'd0 : cursor_q + 3'd1;
	assign cursor_dec = (cursor_q == 3'd0) ? CUR_LAST : cursor_q - 3'd1;

	// Digit entry: validation and clamping for the current cursor position.
	always_comb begin
		ed_hour   = hour_q;
		ed_minute = minute_q;
		ed_second = second_q;
		ed_day    = day_q;
		ed_month  = month_q;
		ed_year   = year_q;
		ed_ok     = 1'b1;
		cand      = '0;
		if (mode_q == TIME_EDIT) begin
			case (cursor_q)
				CUR_HI_TENS: begin
					cand = mul10(key_code) + 7'(hr_u);
					if (key_code > 4'd2) begin
						ed_ok = 1'b0;
					end else begin
						ed_hour = (cand > HOUR_LAST) ? HOUR_CLAMP : cand[4:0];
					end
				end
				CUR_HI_UNITS: begin
					cand = mul10(hr_t) + 7'(key_code);
					if (hr_t == 4'd2 && key_code > 4'd3) begin
						ed_ok = 1'b0;
					end else begin
						ed_hour = cand[4:0];
					end
				end
				CUR_MD_TENS: begin
					cand = mul10(key_code) + 7'(mi_u);
					if (key_code > 4'd5) begin
						ed_ok = 1'b0;
					end else begin
						ed_minute = cand[5:0];
					end
				end
				CUR_MD_UNITS: begin
					cand      = mul10(mi_t) + 7'(key_code);
					ed_minute = cand[5:0];
				end
				CUR_LO_TENS: begin
					cand = mul10(key_code) + 7'(se_u);
					if (key_code > 4'd5) begin
						ed_ok = 1'b0;
					end else begin
						ed_second = cand[5:0];
					end
				end
				default: begin
					cand      = mul10(se_t) + 7'(key_code);
					ed_second = cand[5:0];
				end
			endcase
		end else begin
			case (cursor_q)
				CUR_HI_TENS: begin
					cand = mul10(key_code) + 7'(dy_u);
					if (key_code > 4'd3) begin
						ed_ok = 1'b0;
					end else if (cand == 7'd0) begin
						ed_day = 5'd1;
					end else if (cand > 7'(lim_cur)) begin
						ed_day = lim_cur;
					end else begin
						ed_day = cand[4:0];
					end
				end
				CUR_HI_UNITS: begin
					cand = mul10(dy_t) + 7'(key_code);
					if (cand == 7'd0 || cand > 7'(lim_cur)) begin
						ed_ok = 1'b0;
					end else begin
						ed_day = cand[4:0];
					end
				end
				CUR_MD_TENS: begin
					cand = mul10(key_code) + 7'(mo_u);
					if (key_code > 4'd1) begin
						ed_ok = 1'b0;
					end else if (cand == 7'd0) begin
						ed_month = 4'd1;
					end else if (cand > 7'(MONTH_LAST)) begin
						ed_month = MONTH_LAST;
					end else begin
						ed_month = cand[3:0];
					end
				end
				CUR_MD_UNITS: begin
					cand = mul10(mo_t) + 7'(key_code);
					if (cand == 7'd0 || cand > 7'(MONTH_LAST)) begin
						ed_ok = 1'b0;
					end else begin
						ed_month = cand[3:0];
					end
				end
				CUR_LO_TENS: begin
					cand    = mul10(key_code) + 7'(yr_u);
					ed_year = cand;
				end
				default: begin
					cand    = mul10(yr_t) + 7'(key_code);
					ed_year = cand;
				end
			endcase
			if (cursor_q >= CUR_MD_TENS && day_q > lim_new) begin
				ed_day = lim_new;
			end
		end
	end

	// Event decode and the seconds-to-years rollover cascade.
	always_comb begin
		hour_d     = hour_q;
		minute_d   = minute_q;
		second_d   = second_q;
		day_d      = day_q;
		month_d    = month_q;
		year_d     = year_q;
		prescale_d = prescale_q;
		mode_d     = mode_q;
		cursor_d   = cursor_q;
		sec_flag   = 1'b0;
		day_flag   = 1'b0;
		target     = (op == OP_TIME_SET) ? TIME_EDIT : DATE_EDIT;
		case (op)
			OP_TICK: begin
				prescale_d = prescale_inc;
				if (prescale_inc >= tps) begin
					prescale_d = 8'd0;
					if (mode_q == RUNNING) begin
						sec_flag = 1'b1;
						second_d = second_inc;
						if (second_inc >= SEC_PER_MIN) begin
							second_d = 6'd0;
							minute_d = minute_inc;
							if (minute_inc >= MIN_PER_HOUR) begin
								minute_d = 6'd0;
								hour_d   = hour_inc;
								if (hour_inc >= HOUR_PER_DAY) begin
									hour_d   = 5'd0;
									day_flag = 1'b1;
									day_d    = day_inc[4:0];
									if (day_inc > {1'b0, lim_cur}) begin
										day_d   = 5'd1;
										month_d = month_inc;
										if (month_inc > MONTH_LAST) begin
											month_d = 4'd1;
											year_d  = (year_inc > YEAR_LAST) ? 7'd0 : year_inc;
										end
									end
								end
							end
						end
					end
				end
			end
			OP_TIME_SET, OP_DATE_SET: begin
				if (mode_q == target) begin
					mode_d = RUNNING;
				end else begin
					mode_d   = target;
					cursor_d = 3'd0;
				end
			end
			OP_KEY: begin
				if (mode_q != RUNNING) begin
					if (key_code == KEY_LEFT) begin
						cursor_d = cursor_dec;
					end else if (key_code == KEY_RIGHT) begin
						cursor_d = cursor_inc;
					end else if (key_code <= KEY_DIGIT_MAX && ed_ok) begin
						hour_d   = ed_hour;
						minute_d = ed_minute;
						second_d = ed_second;
						day_d    = ed_day;
						month_d  = ed_month;
						year_d   = ed_year;
						cursor_d = cursor_inc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q     <= 5'd0;
			minute_q   <= 6'd0;
			second_q   <= 6'd0;
			day_q      <= 5'd1;
			month_q    <= 4'd1;
			year_q     <= 7'd0;
			prescale_q <= 8'd0;
			mode_q     <= RUNNING;
			cursor_q   <= 3'd0;
		end else if (take) begin
			hour_q     <= hour_d;
			minute_q   <= minute_d;
			second_q   <= second_d;
			day_q      <= day_d;
			month_q    <= month_d;
			year_q     <= year_d;
			prescale_q <= prescale_d;
			mode_q     <= mode_d;
			cursor_q   <= cursor_d;
		end
	end

	always_comb begin
		res_d.out_hours       = hour_d;
		res_d.out_minutes     = minute_d;
		res_d.out_seconds     = second_d;
		res_d.out_day         = day_d;
		res_d.out_month       = month_d;
		res_d.out_year        = year_d;
		res_d.mode_now        = mode_d;
		res_d.cursor_now      = cursor_d;
		res_d.second_advanced = sec_flag;
		res_d.day_advanced    = day_flag;
	end
endmodule
`default_nettype wire

// ===== rtl/ccds_result_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Result register
// Holds one finished result item until the receiver takes it.
// ---------------------------------------------------------------------------
module ccds_result_stage
	import ccds_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  res_t       res_d,
	output logic       can_take,
	ccds_res_if.source res
);
	logic valid_q;
	res_t data_q;

	assign can_take = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_d;
		end
	end

	assign res.valid           = valid_q;
	assign res.out_hours       = data_q.out_hours;
	assign res.out_minutes     = data_q.out_minutes;
	assign res.out_seconds     = data_q.out_seconds;
	assign res.out_day         = data_q.out_day;
	assign res.out_month       = data_q.out_month;
	assign res.out_year        = data_q.out_year;
	assign res.mode_now        = data_q.mode_now;
	assign res.cursor_now      = data_q.cursor_now;
	assign res.second_advanced = data_q.second_advanced;
	assign res.day_advanced    = data_q.day_advanced;
endmodule
`default_nettype wire

// ===== rtl/clock_calendar_with_digit_setting.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Real-time clock and calendar with digit setting
// Event items come in on evt: a base tick, a time-set or date-set button, or
// a keypad key (digit, cursor left, cursor right). Every item gives exactly
// one result item on res with the full time, date, mode, cursor position and
// the second and day rollover flags.
// The prescaler limit is written over the APB port at address 0; it should
// be changed only while no item is in flight.
// The state and the result register are both loaded at the edge that accepts
// the item. One item is taken every cycle while the receiver keeps up; the
// single result register sets that figure.
// When the receiver stalls, the waiting result holds and evt.ready drops
// until it is taken; in the cycle it is taken a new item may enter.
// Reset clears the clock to 00:00:00, day 1, month 1, year 0, running mode,
// cursor 0, prescaler 0, a limit of 100 ticks, and empties the result
// register.
// ---------------------------------------------------------------------------
module clock_calendar_with_digit_setting
	import ccds_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	ccds_evt_if.sink                   evt,
	ccds_res_if.source                 res
);
	logic [7:0] tps;
	logic       can_take;
	logic       accept;
	res_t       res_d;

	assign evt.ready = can_take;
	assign accept    = evt.valid && can_take;

	ccds_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tps     (tps)
	);

	ccds_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (accept),
		.opcode   (evt.opcode),
		.key_code (evt.key_code),
		.tps      (tps),
		.res_d    (res_d)
	);

	ccds_result_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res_d    (res_d),
		.can_take (can_take),
		.res      (res)
	);
endmodule
`default_nettype wire
